/* src/linear_probe_hash_table_defines.svh */
// assertion macros for the linear probe hash table
// used by the top level only
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
// property that must hold every clock outside reset
`define LPHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* src/lpht_pkg.sv */
// shared types and constants for the linear probe hash table
// no dependencies
package lpht_pkg;
  localparam int SLOTS      = 128;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = 7;
  localparam int HASH_W     = 64;
  localparam int TAG_W      = 7;
  localparam int ST_W       = 3;
  localparam int OP_W       = 2;
  localparam int QDEPTH     = 2;

  localparam logic [7:0] CTRL_EMPTY   = 8'h80;
  localparam logic [7:0] CTRL_DELETED = 8'hFE;
  localparam logic [CNT_W-1:0] MAX_OCC_RESET = 7'd96;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [ST_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [ST_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_DELETED   = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

  // classified item handed from front to back
  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [KEY_BITS-1:0]   key;
    logic [TAG_W-1:0]      tag;
    logic [SLOT_W-1:0]     start;
    logic [VALUE_BITS-1:0] value;
  } lpht_cmd_t;
endpackage

/* src/lpht_ram.sv */
// generic single-port-write, single-read ram with registered read
// no dependencies
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* src/lpht_front.sv */
// front: accepts items, classifies op and hash, queues them for the back
// depends on lpht_pkg
module lpht_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [lpht_pkg::OP_W-1:0]       in_op,
  input  logic [lpht_pkg::KEY_BITS-1:0]   in_key,
  input  logic [lpht_pkg::HASH_W-1:0]     in_hash,
  input  logic [lpht_pkg::VALUE_BITS-1:0] in_value,
  output logic                        cmd_valid,
  output lpht_pkg::lpht_cmd_t         cmd,
  input  logic                        cmd_pop
);
  import lpht_pkg::*;

  lpht_cmd_t q_r [QDEPTH];
  logic      rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic      push;
  lpht_cmd_t in_cmd;

  // classify: op 3 behaves as lookup
  always_comb begin
    in_cmd.op    = (in_op == OP_INSERT || in_op == OP_DELETE) ? in_op : OP_LOOKUP;
    in_cmd.key   = in_key;
    in_cmd.tag   = in_hash[TAG_W-1:0];
    in_cmd.start = in_hash[TAG_W +: SLOT_W];
    in_cmd.value = in_value;
  end

  assign busy      = (cnt_r == 2'(QDEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= in_cmd;
  end
endmodule

/* src/lpht_back.sv */
// back: probe sequencer over control, key and value rams
// depends on lpht_pkg and lpht_ram
module lpht_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  input  lpht_pkg::lpht_cmd_t         cmd,
  output logic                        cmd_pop,
  input  logic [lpht_pkg::CNT_W-1:0]      max_occ,
  output logic                        out_valid,
  output logic [lpht_pkg::ST_W-1:0]       out_status,
  output logic [lpht_pkg::VALUE_BITS-1:0] out_value_out,
  output logic [lpht_pkg::SLOT_W-1:0]     out_slot,
  output logic [lpht_pkg::CNT_W-1:0]      out_entry_count
);
  import lpht_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_VAL   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  lpht_cmd_t         cur_r;
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic [SLOT_W:0]   n_r, n_nxt;
  logic              hit_r, hit_nxt;
  logic [CNT_W-1:0]  live_r, live_nxt, occ_r, occ_nxt;
  logic [SLOTS-1:0]  written_r;
  logic [SLOTS-1:0]  dead_r;

  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic [TAG_W-1:0]      tag_rd;
  logic                  tag_we, key_we, val_we;
  logic [7:0]            ctrl;
  logic                  is_empty;

  // control byte: valid bits give empty/deleted, ram holds the tag
  assign is_empty = !written_r[pos_r];
  assign ctrl     = is_empty ? CTRL_EMPTY
                  : (dead_r[pos_r] ? CTRL_DELETED : {1'b0, tag_rd});

  lpht_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag (
    .clk, .we(tag_we), .waddr(pos_r), .wdata(cur_r.tag), .raddr(pos_nxt), .rdata(tag_rd));
  lpht_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key (
    .clk, .we(key_we), .waddr(pos_r), .wdata(cur_r.key), .raddr(pos_nxt), .rdata(key_rd));
  lpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val (
    .clk, .we(val_we), .waddr(pos_r), .wdata(cur_r.value), .raddr(pos_nxt), .rdata(val_rd));

  assign cmd_pop = (state_r == S_IDLE) && cmd_valid;

  // probe sequencer
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    n_nxt     = n_r;
    hit_nxt   = hit_r;
    live_nxt  = live_r;
    occ_nxt   = occ_r;
    tag_we    = 1'b0;
    key_we    = 1'b0;
    val_we    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          pos_nxt   = cmd.start;
          n_nxt     = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_CHECK;
      S_CHECK: begin
        if (ctrl == {1'b0, cur_r.tag} && key_rd == cur_r.key) begin
          hit_nxt   = 1'b1;
          state_nxt = S_VAL;
        end else if (is_empty) begin
          hit_nxt   = 1'b0;
          state_nxt = S_VAL;
        end else if (n_r == (SLOT_W+1)'(SLOTS - 1)) begin
          hit_nxt   = 1'b0;
          pos_nxt   = cur_r.start;
          state_nxt = S_VAL;
        end else begin
          pos_nxt   = pos_r + SLOT_W'(1);
          n_nxt     = n_r + (SLOT_W+1)'(1);
          state_nxt = S_READ;
        end
      end
      S_VAL: begin
        // val_rd now holds the value at pos_r
        state_nxt = S_DONE;
        if (cur_r.op == OP_INSERT) begin
          if (hit_r) begin
            val_we = 1'b1;
          end else if (occ_r < max_occ && is_empty) begin
            tag_we   = 1'b1;
            key_we   = 1'b1;
            val_we   = 1'b1;
            live_nxt = live_r + CNT_W'(1);
            occ_nxt  = occ_r + CNT_W'(1);
          end
        end else if (cur_r.op == OP_DELETE && hit_r && live_r != '0) begin
          live_nxt = live_r - CNT_W'(1);
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      live_r    <= '0;
      occ_r     <= '0;
      hit_r     <= 1'b0;
      written_r <= '0;
      dead_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      live_r    <= live_nxt;
      occ_r     <= occ_nxt;
      hit_r     <= hit_nxt;
      out_valid <= (state_r == S_VAL);
      if (tag_we) begin
        written_r[pos_r] <= 1'b1;
        dead_r[pos_r]    <= 1'b0;
      end
      if (state_r == S_VAL && cur_r.op == OP_DELETE && hit_r) dead_r[pos_r] <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    n_r   <= n_nxt;
    if (cmd_pop) cur_r <= cmd;
    if (state_r == S_VAL) begin
      out_slot        <= pos_r;
      out_entry_count <= live_nxt;
      out_value_out   <= '0;
      unique case (cur_r.op)
        OP_INSERT: begin
          if (hit_r) out_status <= ST_FOUND;
          else if (occ_r < max_occ && is_empty) out_status <= ST_INSERTED;
          else out_status <= ST_FULL;
        end
        OP_DELETE: begin
          out_status <= hit_r ? ST_DELETED : ST_NOT_FOUND;
          if (hit_r) out_value_out <= val_rd;
        end
        default: begin
          out_status <= hit_r ? ST_FOUND : ST_NOT_FOUND;
          if (hit_r) out_value_out <= val_rd;
        end
      endcase
    end
  end
endmodule

/* src/linear_probe_hash_table.sv */
// linear probing hash table: each item passes the front queue, then the back's
// idle, read and check states (read and check repeat per slot probed), val and done.
// the probe sequencer takes a new item only after it is through with the last one;
// a 2-item queue takes start during a probe.
// rst_n synchronous: all slots empty, counts zero, max_occupancy 96.
// results are strobed on out_valid for one cycle; the receiver cannot stall.
`include "linear_probe_hash_table_defines.svh"
module linear_probe_hash_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [lpht_pkg::OP_W-1:0]       in_op,
  input  logic [lpht_pkg::KEY_BITS-1:0]   in_key,
  input  logic [lpht_pkg::HASH_W-1:0]     in_hash,
  input  logic [lpht_pkg::VALUE_BITS-1:0] in_value,
  input  logic                            cfg_we,
  input  logic [lpht_pkg::CNT_W-1:0]      cfg_max_occupancy,
  output logic                            out_valid,
  output logic [lpht_pkg::ST_W-1:0]       out_status,
  output logic [lpht_pkg::VALUE_BITS-1:0] out_value_out,
  output logic [lpht_pkg::SLOT_W-1:0]     out_slot,
  output logic [lpht_pkg::CNT_W-1:0]      out_entry_count
);
  import lpht_pkg::*;

  logic             cmd_valid, cmd_pop;
  lpht_cmd_t        cmd;
  logic [CNT_W-1:0] max_occ_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) max_occ_r <= MAX_OCC_RESET;
    else if (cfg_we) max_occ_r <= cfg_max_occupancy;
  end

  lpht_front u_front (
    .clk, .rst_n, .start, .busy, .in_op, .in_key, .in_hash, .in_value,
    .cmd_valid, .cmd, .cmd_pop);

  lpht_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_pop, .max_occ(max_occ_r),
    .out_valid, .out_status, .out_value_out, .out_slot, .out_entry_count);

  // checks
  `LPHT_ASSERT(a_pop_valid, !cmd_pop || cmd_valid, "pop from empty queue")
  `LPHT_ASSERT(a_status_range, !out_valid || out_status <= ST_FULL, "bad status")
  `LPHT_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held")
endmodule

/* test/tb_linear_probe_hash_table.sv */
// testbench for the linear probe hash table: random and directed lookups,
// inserts and deletes checked against a behavioral table model
// depends on lpht_pkg and linear_probe_hash_table
`timescale 1ns / 100ps
module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  typedef struct {
    logic [OP_W-1:0]       op;
    logic [KEY_BITS-1:0]   key;
    logic [HASH_W-1:0]     hash;
    logic [VALUE_BITS-1:0] value;
    bit                    hold_idle;
  } table_op_t;

  typedef struct {
    logic [ST_W-1:0]       status;
    logic [VALUE_BITS-1:0] value_out;
    logic [SLOT_W-1:0]     slot;
    logic [CNT_W-1:0]      entry_count;
  } table_result_t;

  logic clk, rst_n, start, busy, cfg_we, out_valid;
  logic [OP_W-1:0]       in_op;
  logic [KEY_BITS-1:0]   in_key;
  logic [HASH_W-1:0]     in_hash;
  logic [VALUE_BITS-1:0] in_value;
  logic [CNT_W-1:0]      cfg_max_occupancy;
  logic [ST_W-1:0]       out_status;
  logic [VALUE_BITS-1:0] out_value_out;
  logic [SLOT_W-1:0]     out_slot;
  logic [CNT_W-1:0]      out_entry_count;

  linear_probe_hash_table u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_key(in_key), .in_hash(in_hash), .in_value(in_value),
    .cfg_we(cfg_we), .cfg_max_occupancy(cfg_max_occupancy),
    .out_valid(out_valid), .out_status(out_status),
    .out_value_out(out_value_out), .out_slot(out_slot),
    .out_entry_count(out_entry_count)
  );

  // table model state
  logic [7:0]            ctrl_mem [SLOTS];
  logic [KEY_BITS-1:0]   key_mem [SLOTS];
  logic [VALUE_BITS-1:0] val_mem [SLOTS];
  int unsigned live_entries, occupied_slots;
  logic [CNT_W-1:0] occ_limit;

  table_op_t     pending_ops[$];
  table_result_t expected_results[$];
  int error_count;
  int idle_cnt;
  bit driving;
  logic busy_q;
  bit took;
  table_op_t cur_op;

  // key pool keeps hits frequent; hashes share few start slots for collisions
  logic [KEY_BITS-1:0] key_pool [16];

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // compute the result of one item and update the table model
  function automatic table_result_t table_apply(table_op_t t);
    table_result_t r;
    int unsigned first, p, n;
    logic [TAG_W-1:0] tag;
    bit hit;
    first = 32'(t.hash[SLOT_W+TAG_W-1:TAG_W]);
    tag = t.hash[TAG_W-1:0];
    p = first;
    hit = 0;
    r.slot = SLOT_W'(first);
    for (n = 0; n < SLOTS; n++) begin
      if (ctrl_mem[p] == {1'b0, tag} && key_mem[p] == t.key) begin
        hit = 1; r.slot = SLOT_W'(p); break;
      end
      if (ctrl_mem[p] == CTRL_EMPTY) begin
        r.slot = SLOT_W'(p); break;
      end
      p = (p + 1) % SLOTS;
    end
    r.value_out = '0;
    if (t.op == OP_INSERT) begin
      if (hit) begin
        val_mem[r.slot] = t.value;
        r.status = ST_FOUND;
      end else if (occupied_slots >= occ_limit || ctrl_mem[r.slot] != CTRL_EMPTY) begin
        r.status = ST_FULL;
      end else begin
        ctrl_mem[r.slot] = {1'b0, tag};
        key_mem[r.slot] = t.key;
        val_mem[r.slot] = t.value;
        live_entries++;
        occupied_slots++;
        r.status = ST_INSERTED;
      end
    end else if (t.op == OP_DELETE) begin
      if (hit) begin
        r.value_out = val_mem[r.slot];
        ctrl_mem[r.slot] = CTRL_DELETED;
        if (live_entries > 0) live_entries--;
        r.status = ST_DELETED;
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end else begin
      if (hit) r.value_out = val_mem[r.slot];
      r.status = hit ? ST_FOUND : ST_NOT_FOUND;
    end
    r.entry_count = live_entries[CNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // driver: one item per handshake, random gaps between items
  always @(negedge clk) begin
    if (!rst_n || !driving) begin
      start <= 1'b0;
    end else if (start && !busy_q) begin
      // previous item taken at the last rising edge
      next_item();
    end else if (!start) begin
      next_item();
    end
  end

  always @(posedge clk) begin
    busy_q <= busy;
    took = rst_n && start && !busy;
    if (took) expected_results.push_back(table_apply(cur_op));
  end

  task automatic next_item();
    if (idle_cnt > 0) begin
      idle_cnt--;
      start <= 1'b0;
    end else if (pending_ops.size() > 0 &&
                 !(pending_ops[0].hold_idle && expected_results.size() > 0)) begin
      cur_op = pending_ops.pop_front();
      in_op <= cur_op.op;
      in_key <= cur_op.key;
      in_hash <= cur_op.hash;
      in_value <= cur_op.value;
      start <= 1'b1;
      idle_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    end else begin
      start <= 1'b0;
    end
  endtask

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    table_result_t w;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        error_count++;
      end else begin
        w = expected_results.pop_front();
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_value_out !== w.value_out)
          report_mismatch("value_out", out_value_out, w.value_out);
        if (out_slot !== w.slot) report_mismatch("slot", out_slot, w.slot);
        if (out_entry_count !== w.entry_count)
          report_mismatch("entry_count", out_entry_count, w.entry_count);
      end
    end
  end

  function automatic table_op_t make_op(logic [OP_W-1:0] op, logic [KEY_BITS-1:0] k,
                                        logic [HASH_W-1:0] h, logic [VALUE_BITS-1:0] v);
    table_op_t t;
    t.op = op; t.key = k; t.hash = h; t.value = v; t.hold_idle = 0;
    return t;
  endfunction

  // random item over the key pool, hash derived per key with random upper bits
  function automatic table_op_t random_op(int unsigned slot_span);
    int unsigned ki;
    logic [HASH_W-1:0] h;
    logic [OP_W-1:0] op;
    ki = $urandom_range(0, 15);
    h = {$urandom, $urandom};
    h[TAG_W-1:0] = key_pool[ki][TAG_W-1:0];
    h[SLOT_W+TAG_W-1:TAG_W] = SLOT_W'(key_pool[ki][15:8] % slot_span);
    case ($urandom_range(0, 9))
      0, 1, 2:    op = OP_LOOKUP;
      3, 4, 5, 6: op = OP_INSERT;
      7, 8:       op = OP_DELETE;
      default:    op = 2'd3;
    endcase
    if ($urandom_range(0, 19) == 0) begin
      // fresh key, fully random hash
      return make_op(op, $urandom, {$urandom, $urandom}, $urandom);
    end
    return make_op(op, key_pool[ki], h, $urandom);
  endfunction

  task automatic wait_drained();
    while (pending_ops.size() > 0 || expected_results.size() > 0 || start)
      @(posedge clk);
    repeat (2 * SLOTS + 10) @(posedge clk);
  endtask

  task automatic write_limit(logic [CNT_W-1:0] v);
    @(negedge clk);
    cfg_max_occupancy <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    occ_limit = v;
  endtask

  // phases: directed, then random under several thresholds
  initial begin
    logic [CNT_W-1:0] limits [4];
    table_op_t t;
    int i, ph;
    error_count = 0;
    idle_cnt = 0;
    driving = 0;
    start = 0; cfg_we = 0; cfg_max_occupancy = MAX_OCC_RESET;
    in_op = '0; in_key = '0; in_hash = '0; in_value = '0;
    rst_n = 0;
    for (i = 0; i < SLOTS; i++) ctrl_mem[i] = CTRL_EMPTY;
    live_entries = 0; occupied_slots = 0; occ_limit = MAX_OCC_RESET;
    for (i = 0; i < 16; i++) key_pool[i] = $urandom;
    key_pool[0] = '0; key_pool[1] = '1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes, all ops, op three, update, missing delete, tombstone
    pending_ops.push_back(make_op(OP_LOOKUP, '0, '0, '0));
    pending_ops.push_back(make_op(OP_INSERT, '0, '0, '1));
    pending_ops.push_back(make_op(OP_INSERT, '1, '1, 32'h1234_5678));
    pending_ops.push_back(make_op(OP_INSERT, 32'h5, 64'h0, 32'hA5A5_A5A5));
    pending_ops.push_back(make_op(OP_INSERT, '0, '0, 32'h0BAD_F00D));
    pending_ops.push_back(make_op(2'd3, '0, '0, '0));
    pending_ops.push_back(make_op(OP_LOOKUP, '1, '1, '0));
    pending_ops.push_back(make_op(OP_DELETE, '0, '0, '0));
    pending_ops.push_back(make_op(OP_DELETE, '0, '0, '0));
    pending_ops.push_back(make_op(OP_LOOKUP, 32'h5, 64'h0, '0));
    pending_ops.push_back(make_op(OP_INSERT, 32'h9, 64'hFFFF_FFFF_FFFF_FF80, 32'h1));
    pending_ops.push_back(make_op(OP_INSERT, 32'hA, 64'hFFFF_FFFF_FFFF_FF80, 32'h2));
    t = make_op(OP_LOOKUP, 32'hA, 64'hFFFF_FFFF_FFFF_FF80, '0);
    t.hold_idle = 1;
    pending_ops.push_back(t);
    pending_ops.push_back(make_op(OP_DELETE, '1, '1, '0));
    driving = 1;
    wait_drained();

    // threshold of one with occupancy above it: new keys refused, update allowed
    write_limit(7'd1);
    pending_ops.push_back(make_op(OP_INSERT, 32'h77, 64'h3C00, '0));
    pending_ops.push_back(make_op(OP_INSERT, 32'h9, 64'hFFFF_FFFF_FFFF_FF80, 32'h33));
    wait_drained();

    // random phases; the last fills the table up to its limit for long probes
    limits[0] = 7'd8; limits[1] = 7'd127; limits[2] = 7'd40; limits[3] = 7'd127;
    for (ph = 0; ph < 4; ph++) begin
      write_limit(limits[ph]);
      for (i = 0; i < 220; i++) begin
        t = random_op(ph == 3 ? SLOTS : 16);
        if (ph == 3 && i < 140) begin
          t.op = OP_INSERT;
          t.key = $urandom;
          t.hash = {$urandom, $urandom};
        end
        if (i == 100) t.hold_idle = 1;
        pending_ops.push_back(t);
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+src
src/lpht_pkg.sv
src/lpht_ram.sv
src/lpht_front.sv
src/lpht_back.sv
src/linear_probe_hash_table.sv
test/tb_linear_probe_hash_table.sv
